// ===== rtl/balu_pkg.sv =====
// ============================================================================
// balu_pkg
// Shared types and codes for the bounded array list engine.
// ============================================================================
`default_nettype none

package balu_pkg;

    localparam int ACT_W  = 3;
    localparam int POS_W  = 6;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 7;
    localparam int ST_W   = 2;
    localparam int ADDR_W = 2;

    localparam logic [ADDR_W-1:0] ADDR_CAPACITY = 2'd0;
    localparam logic [CNT_W-1:0]  CAPACITY_RST  = 7'd64;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

    typedef enum logic [ACT_W-1:0] {
        OP_APPEND  = 3'd0,
        OP_INSERT  = 3'd1,
        OP_SEARCH  = 3'd2,
        OP_READ    = 3'd3,
        OP_WRITE   = 3'd4,
        OP_REMLAST = 3'd5,
        OP_REMAT   = 3'd6,
        OP_NOP     = 3'd7
    } op_t;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic                    found;
        logic [POS_W-1:0]        found_position;
        logic signed [VAL_W-1:0] read_value;
        logic [CNT_W-1:0]        count;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/balu_front.sv =====
// ============================================================================
// balu_front
// Accepts request items, decodes the action and stores the item word, and
// holds them in a two-entry command queue for the back end.
// ============================================================================
`default_nettype none

module balu_front #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [balu_pkg::ACT_W-1:0]    action,
    input  wire logic [balu_pkg::POS_W-1:0]    position,
    input  wire logic signed [balu_pkg::VAL_W-1:0] value,
    output logic                               cmd_valid,
    input  wire logic                          cmd_take,
    output balu_pkg::op_t                      cmd_op,
    output logic [balu_pkg::POS_W-1:0]         cmd_pos,
    output logic [DATA_WIDTH-1:0]              cmd_word
);
    import balu_pkg::*;

    op_t                   q_op_reg   [2];
    logic [POS_W-1:0]      q_pos_reg  [2];
    logic [DATA_WIDTH-1:0] q_word_reg [2];
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    logic [1:0]            cnt_reg;

    op_t                   op_dec;
    logic [DATA_WIDTH-1:0] word_dec;
    logic                  push_ok;
    logic                  take_ok;

    // every 3-bit action code has an op_t member
    assign op_dec = op_t'(action);

    // stored word: low DATA_WIDTH bits, zero filled above 32
    generate
        if (DATA_WIDTH <= VAL_W)
        begin : g_narrow
            assign word_dec = value[DATA_WIDTH-1:0];
        end
        else
        begin : g_wide
            assign word_dec = {{(DATA_WIDTH-VAL_W){1'b0}}, value};
        end
    endgenerate

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign push_ok   = push && !full;
    assign take_ok   = cmd_take && cmd_valid;

    assign cmd_op   = q_op_reg[rd_ptr_reg];
    assign cmd_pos  = q_pos_reg[rd_ptr_reg];
    assign cmd_word = q_word_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_op_reg[wr_ptr_reg]   <= op_dec;
            q_pos_reg[wr_ptr_reg]  <= position;
            q_word_reg[wr_ptr_reg] <= word_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (take_ok)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push_ok && !take_ok)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (take_ok && !push_ok)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/balu_back.sv =====
// ============================================================================
// balu_back
// Executes list commands against the entry memory, one memory word per
// cycle for shifts and search, and holds one result item.
// ============================================================================
`default_nettype none

module balu_back #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [balu_pkg::CNT_W-1:0] capacity,
    input  wire logic                       cmd_valid,
    output logic                            cmd_take,
    input  wire balu_pkg::op_t              cmd_op,
    input  wire logic [balu_pkg::POS_W-1:0] cmd_pos,
    input  wire logic [DATA_WIDTH-1:0]      cmd_word,
    output balu_pkg::res_t                  res,
    output logic                            res_valid,
    input  wire logic                       pop
);
    import balu_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int PW = (FW > POS_W) ? FW : POS_W;
    localparam int CW = (FW > CNT_W) ? FW : CNT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_SHUP = 3'd3;
    localparam logic [2:0] S_SHDN = 3'd4;

    logic [DATA_WIDTH-1:0] entry_mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    logic [2:0]            state_reg,  state_next;
    logic [FW-1:0]         fill_reg,   fill_next;
    logic [AW-1:0]         idx_reg,    idx_next;
    logic [AW-1:0]         pos_reg,    pos_next;
    logic [DATA_WIDTH-1:0] word_reg,   word_next;
    res_t                  res_reg;
    logic                  res_valid_reg;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [AW-1:0]         raddr;
    logic                  res_load;
    res_t                  res_new;
    logic                  slot_free;
    logic                  is_full;
    logic [PW-1:0]         pos_w;
    logic [PW-1:0]         fill_w;
    logic [VAL_W-1:0]      rd_ext;

    generate
        if (DATA_WIDTH < VAL_W)
        begin : g_sext
            assign rd_ext = {{(VAL_W-DATA_WIDTH){rdata_reg[DATA_WIDTH-1]}}, rdata_reg};
        end
        else
        begin : g_trunc
            assign rd_ext = rdata_reg[VAL_W-1:0];
        end
    endgenerate

    assign slot_free = !res_valid_reg || pop;
    assign is_full   = (CW'(fill_reg) >= CW'(capacity)) || (fill_reg >= FW'(DEPTH));
    assign pos_w     = PW'(cmd_pos);
    assign fill_w    = PW'(fill_reg);

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        word_next  = word_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = rdata_reg;
        raddr      = idx_reg;
        cmd_take   = 1'b0;
        res_load   = 1'b0;
        res_new    = '{status: ST_OK, found: 1'b0, found_position: '0,
                       read_value: '0, count: '0};

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    cmd_take  = 1'b1;
                    word_next = cmd_word;
                    pos_next  = AW'(cmd_pos);
                    case (cmd_op)
                        OP_APPEND:
                        begin
                            res_load = 1'b1;
                            if (is_full)
                            begin
                                res_new.status = ST_FULL;
                            end
                            else
                            begin
                                we        = 1'b1;
                                waddr     = AW'(fill_reg);
                                wdata     = cmd_word;
                                fill_next = fill_reg + FW'(1);
                            end
                        end
                        OP_INSERT:
                        begin
                            if (is_full)
                            begin
                                res_load       = 1'b1;
                                res_new.status = ST_FULL;
                            end
                            else if (pos_w > fill_w)
                            begin
                                res_load       = 1'b1;
                                res_new.status = ST_RANGE;
                            end
                            else if (pos_w == fill_w)
                            begin
                                res_load  = 1'b1;
                                we        = 1'b1;
                                waddr     = AW'(cmd_pos);
                                wdata     = cmd_word;
                                fill_next = fill_reg + FW'(1);
                            end
                            else
                            begin
                                raddr      = AW'(fill_reg - FW'(1));
                                idx_next   = AW'(fill_reg);
                                state_next = S_SHUP;
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_load = 1'b1;
                            end
                            else
                            begin
                                raddr      = '0;
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        OP_READ:
                        begin
                            if (pos_w >= fill_w)
                            begin
                                res_load       = 1'b1;
                                res_new.status = ST_RANGE;
                            end
                            else
                            begin
                                raddr      = AW'(cmd_pos);
                                state_next = S_READ;
                            end
                        end
                        OP_WRITE:
                        begin
                            res_load = 1'b1;
                            if (pos_w >= fill_w)
                            begin
                                res_new.status = ST_RANGE;
                            end
                            else
                            begin
                                we    = 1'b1;
                                waddr = AW'(cmd_pos);
                                wdata = cmd_word;
                            end
                        end
                        OP_REMLAST:
                        begin
                            res_load = 1'b1;
                            if (fill_reg == '0)
                            begin
                                res_new.status = ST_EMPTY;
                            end
                            else
                            begin
                                fill_next = fill_reg - FW'(1);
                            end
                        end
                        OP_REMAT:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_load       = 1'b1;
                                res_new.status = ST_EMPTY;
                            end
                            else if (pos_w >= fill_w)
                            begin
                                res_load       = 1'b1;
                                res_new.status = ST_RANGE;
                            end
                            else if (pos_w == fill_w - PW'(1))
                            begin
                                res_load  = 1'b1;
                                fill_next = fill_reg - FW'(1);
                            end
                            else
                            begin
                                raddr      = AW'(cmd_pos) + AW'(1);
                                idx_next   = AW'(cmd_pos);
                                state_next = S_SHDN;
                            end
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_load           = 1'b1;
                res_new.read_value = rd_ext;
                state_next         = S_IDLE;
            end
            S_SCAN:
            begin
                // rdata_reg holds entry idx_reg
                raddr = idx_reg + AW'(1);
                if (rdata_reg == word_reg)
                begin
                    res_load               = 1'b1;
                    res_new.found          = 1'b1;
                    res_new.found_position = POS_W'(idx_reg);
                    state_next             = S_IDLE;
                end
                else if (FW'(idx_reg) + FW'(1) == fill_reg)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_SHUP:
            begin
                // rdata_reg holds entry idx_reg - 1
                we = 1'b1;
                if (idx_reg == pos_reg)
                begin
                    wdata      = word_reg;
                    fill_next  = fill_reg + FW'(1);
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    raddr    = idx_reg - AW'(2);
                    idx_next = idx_reg - AW'(1);
                end
            end
            S_SHDN:
            begin
                // rdata_reg holds entry idx_reg + 1
                we       = 1'b1;
                raddr    = idx_reg + AW'(2);
                idx_next = idx_reg + AW'(1);
                if (FW'(idx_reg) + FW'(2) == fill_reg)
                begin
                    fill_next  = fill_reg - FW'(1);
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_new.count = CNT_W'(fill_next);
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entry_mem[waddr] <= wdata;
        end
        rdata_reg <= entry_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        pos_reg  <= pos_next;
        word_reg <= word_next;
        if (res_load)
        begin
            res_reg <= res_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/bounded_array_list_engine_unit.sv =====
// ============================================================================
// bounded_array_list_engine_unit
// Ordered list of signed words with append, insert, search, read, write and
// removals; front queue decouples request intake from the executing back end.
// ============================================================================
//
//   channel   handshake               payload
//   request   push / full             action, position, value
//   result    pop / empty             status, found, found_position,
//                                     read_value, count
//   config    psel/penable/pwrite     paddr, pwdata, prdata (capacity @ 0x0)
//
// Back end: append, write, remove_last and unused codes finish on acceptance;
// read passes through a read state, search scans entries upward, insert
// shifts entries up and remove_at shifts them down; the entry memory moves
// one word a cycle. Requests pass through the two-entry request queue.
// Reset clears count and queues; entries are not cleared. Results wait in
// one output register while the request queue keeps filling.
`default_nettype none

module bounded_array_list_engine_unit #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [balu_pkg::ACT_W-1:0]        action,
    input  wire logic [balu_pkg::POS_W-1:0]        position,
    input  wire logic signed [balu_pkg::VAL_W-1:0] value,
    input  wire logic                              pop,
    output logic                                   empty,
    output logic [balu_pkg::ST_W-1:0]              status,
    output logic                                   found,
    output logic [balu_pkg::POS_W-1:0]             found_position,
    output logic signed [balu_pkg::VAL_W-1:0]      read_value,
    output logic [balu_pkg::CNT_W-1:0]             count,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [balu_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import balu_pkg::*;

    logic [CNT_W-1:0]      capacity_reg;
    logic                  cmd_valid;
    logic                  cmd_take;
    op_t                   cmd_op;
    logic [POS_W-1:0]      cmd_pos;
    logic [DATA_WIDTH-1:0] cmd_word;
    res_t                  res;
    logic                  res_valid;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CAPACITY) ? 32'(capacity_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RST;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY))
        begin
            capacity_reg <= pwdata[CNT_W-1:0];
        end
    end

    balu_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .action    (action),
        .position  (position),
        .value     (value),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd_op    (cmd_op),
        .cmd_pos   (cmd_pos),
        .cmd_word  (cmd_word)
    );

    balu_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (capacity_reg),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd_op    (cmd_op),
        .cmd_pos   (cmd_pos),
        .cmd_word  (cmd_word),
        .res       (res),
        .res_valid (res_valid),
        .pop       (pop)
    );

    assign empty          = !res_valid;
    assign status         = res.status;
    assign found          = res.found;
    assign found_position = res.found_position;
    assign read_value     = res.read_value;
    assign count          = res.count;

endmodule

`default_nettype wire

// ===== rtl/balu_checker.sv =====
// ============================================================================
// balu_checker
// Port-level checks on the result channel of the list engine.
// ============================================================================
`default_nettype none

module balu_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         pop,
    input  wire logic                         empty,
    input  wire logic [balu_pkg::ST_W-1:0]    status,
    input  wire logic                         found,
    input  wire logic [balu_pkg::POS_W-1:0]   found_position,
    input  wire logic [balu_pkg::VAL_W-1:0]   read_value,
    input  wire logic [balu_pkg::CNT_W-1:0]   count
);
    import balu_pkg::*;

    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(count)
                              && $stable(read_value) && $stable(found_position)))
        else $error("waiting result item changed");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (found || read_value != '0 || found_position != '0))
            |-> (status == ST_OK))
        else $error("search or read data with failing status");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_EMPTY) |-> (count == '0))
        else $error("empty status with nonzero count");

endmodule

bind bounded_array_list_engine_unit balu_checker u_balu_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop            (pop),
    .empty          (empty),
    .status         (status),
    .found          (found),
    .found_position (found_position),
    .read_value     (read_value),
    .count          (count)
);

`default_nettype wire
